// File: design/ifsc_pkg.sv
// ----------------------------------------------------------------------------
// IMU frame sync and checksum package
// Shared constants, types and the store request bundle for the frame
// receiver.
// ----------------------------------------------------------------------------
package ifsc_pkg;

  // Frame geometry: header bytes, body and checksum byte, then the sensor id.
  localparam int unsigned FRAME_LEN   = 12;
  localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
  localparam int unsigned SUM_LEN     = FRAME_LEN - 2;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);

  // Header bytes and the reset value of the sensor id register.
  localparam logic [7:0] HDR_FIRST     = 8'h55;
  localparam logic [7:0] HDR_SECOND    = 8'h53;
  localparam logic [7:0] SENSOR_ID_RST = 8'h01;

  // Store positions used for compares, sized to the index width.
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(STORE_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_SUM_LEN  = IDX_W'(SUM_LEN);
  localparam logic [IDX_W-1:0] IDX_ONE      = IDX_W'(1);

  // Header hunt phase.
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  // Sequencer state.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_LOAD = 2'd2,
    ST_ID   = 2'd3
  } seq_state_e;

  // Request from the sequencer to the frame store.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

endpackage

// File: design/imu_frame_sync_checksum.sv
// ----------------------------------------------------------------------------
// IMU frame sync and checksum receiver
// Header synchronized byte frame receiver with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the rx channel, one transfer per byte, while
// rx_stall_o is low. The block hunts for 0x55 then 0x53, stores the frame and
// sums all bytes before the checksum byte with one shared 8-bit adder as they
// arrive. When the checksum byte matches, rx_stall_o rises and the sequencer
// plays out a frame of FRAME_LEN bytes, each stored byte by a store read,
// then an output load. The last byte is the sensor id with out_last_o set. A
// stall on the output channel holds the output register and pauses the
// sequencer. A mismatched frame yields nothing and the hunt restarts at once.
// The config channel is always ready and writes the sensor id; write it only
// while the block is idle. Reset clears the hunt, empties the output and sets
// the sensor id to 1; the store needs no clearing.
// ----------------------------------------------------------------------------
module imu_frame_sync_checksum import ifsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_sensor_id_i,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  store_req_t store_req;
  logic [7:0] store_rdata;

  assign cfg_ready_o = 1'b1;

  // Sequencer with the shared checksum adder.
  ifsc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_sensor_id_i (cfg_sensor_id_i),
    .rx_valid_i      (rx_valid_i),
    .rx_byte_i       (rx_byte_i),
    .rx_stall_o      (rx_stall_o),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .out_last_o      (out_last_o),
    .store_req_o     (store_req),
    .store_rdata_i   (store_rdata)
  );

  // Frame store.
  ifsc_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

endmodule

// File: design/ifsc_store.sv
// ----------------------------------------------------------------------------
// IMU frame store
// Single write, single read byte memory holding the frame being received.
// The read data is registered.
// ----------------------------------------------------------------------------
module ifsc_store import ifsc_pkg::*; (
  input  logic       clk_i,
  input  store_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ifsc_ctrl.sv
// ----------------------------------------------------------------------------
// IMU frame sequencer
// Hunts for the header, writes the frame to the store, runs the checksum
// through one shared 8-bit adder and plays a good frame out byte by byte.
// ----------------------------------------------------------------------------
module ifsc_ctrl import ifsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_sensor_id_i,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       rx_stall_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output store_req_t store_req_o,
  input  logic [7:0] store_rdata_i
);

  seq_state_e       state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       sensor_id_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             rx_xfer;
  logic             out_free;
  logic [7:0]       sum_add;

  assign rx_xfer  = rx_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  // The one adder shared by every checksum byte after the first.
  assign sum_add  = sum_q + rx_byte_i;

  // Sensor id register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_id_q <= SENSOR_ID_RST;
    end else if (cfg_valid_i) begin
      sensor_id_q <= cfg_sensor_id_i;
    end
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HUNT;
      count_q     <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  // Next state, store requests and output loading.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    count_d     = count_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    store_req_o = '{we: 1'b0, waddr: count_q, wdata: rx_byte_i, re: 1'b0, raddr: idx_q};

    case (state_q)
      ST_IDLE: begin
        if (rx_xfer) begin
          case (phase_q)
            PH_SECOND: begin
              if (rx_byte_i == HDR_SECOND) begin
                store_req_o.we = 1'b1;
                count_d        = count_q + IDX_ONE;
                sum_d          = sum_add;
                phase_d        = PH_BODY;
              end else begin
                count_d = '0;
                phase_d = PH_HUNT;
              end
            end
            PH_BODY: begin
              store_req_o.we = 1'b1;
              if (count_q == IDX_LAST) begin
                // Checksum byte: compare and restart the hunt either way.
                count_d = '0;
                phase_d = PH_HUNT;
                if (sum_q == rx_byte_i) begin
                  idx_d   = '0;
                  state_d = ST_READ;
                end
              end else begin
                count_d = count_q + IDX_ONE;
                if (count_q < IDX_SUM_LEN) begin
                  sum_d = sum_add;
                end
              end
            end
            default: begin
              count_d = '0;
              phase_d = PH_HUNT;
              if (rx_byte_i == HDR_FIRST) begin
                store_req_o.we    = 1'b1;
                store_req_o.waddr = '0;
                count_d           = IDX_ONE;
                sum_d             = rx_byte_i;
                phase_d           = PH_SECOND;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        store_req_o.re = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = store_rdata_i;
          out_last_d  = 1'b0;
          if (idx_q == IDX_LAST) begin
            state_d = ST_ID;
          end else begin
            idx_d   = idx_q + IDX_ONE;
            state_d = ST_READ;
          end
        end
      end
      ST_ID: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = sensor_id_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rx_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// File: design/ifsc_checker.sv
// ----------------------------------------------------------------------------
// IMU frame receiver port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module ifsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled output changed");

  // While a frame is still being played out, no byte is taken in.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> rx_stall_o)
    else $error("input accepted during frame playout");

  // A result never rises with its last byte set, and only while the input is stalled.
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !out_last_o && rx_stall_o)
    else $error("frame started without playout");

  // Once the last byte transfers, the next byte held is never another last byte.
  a_no_double_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o && !out_stall_i |=> !(out_valid_o && out_last_o))
    else $error("two last bytes in a row");

endmodule

bind imu_frame_sync_checksum ifsc_checker u_ifsc_checker (.*);
